/* rtl/wave_equation_symplectic_step_top_defines.svh */
// Assertion macros for the wave equation step block.
// Included by the top level; depends on nothing else.
`ifndef WAVE_EQUATION_SYMPLECTIC_STEP_TOP_DEFINES_SVH
`define WAVE_EQUATION_SYMPLECTIC_STEP_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define WES_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wave step assertion failed");

// Next-cycle implication, disabled while reset is low.
`define WES_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wave step assertion failed");

`endif

/* rtl/wes_pkg.sv */
// Shared types, constants and codes for the wave equation step block.
// Depends on nothing; used by every module of the block.
package wes_pkg;

  localparam int MAX_POINTS = 512;
  localparam int FRAC_BITS  = 24;
  localparam int ADDR_W     = $clog2(MAX_POINTS);
  localparam int NPTS_W     = ADDR_W + 1;
  localparam int DATA_W     = 32;
  localparam int HALF_W     = 25;
  localparam int GAIN_W     = 31;
  localparam int MAG_W      = DATA_W + 2;
  localparam int PART_W     = MAG_W / 2;
  localparam int PROD_W     = PART_W + GAIN_W;
  localparam int SUM_W      = PROD_W + PART_W + 1;
  localparam int SCL_W      = SUM_W - FRAC_BITS;

  localparam logic [HALF_W-1:0] HALF_RESET = HALF_W'(83886);
  localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(209715200);
  localparam logic [NPTS_W-1:0] NPTS_RESET = NPTS_W'(500);
  localparam logic [NPTS_W-1:0] NPTS_MIN   = NPTS_W'(3);
  localparam logic [NPTS_W-1:0] NPTS_MAX   = NPTS_W'(MAX_POINTS);

  localparam logic KIND_READ = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  localparam logic [1:0] REG_HALF_STEP = 2'd0;
  localparam logic [1:0] REG_GAIN      = 2'd1;
  localparam logic [1:0] REG_NPTS      = 2'd2;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_STEP  = 2'd1,
    CMD_READ  = 2'd2
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WRITE,
    ST_RD_ISSUE,
    ST_RD_RESP,
    ST_RD,
    ST_LD,
    ST_M0,
    ST_M1,
    ST_SC,
    ST_WR,
    ST_F0,
    ST_F1,
    ST_F2,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]              cmd;
    logic [ADDR_W-1:0]       index;
    logic signed [DATA_W-1:0] position;
    logic signed [DATA_W-1:0] momentum;
  } in_item_t;

  typedef struct packed {
    logic                     kind;
    logic [ADDR_W-1:0]        index_res;
    logic signed [DATA_W-1:0] position_res;
    logic signed [DATA_W-1:0] momentum_res;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic              cap_in;
    logic              rd_en;
    logic              use_idx;
    logic [ADDR_W-1:0] q_addr;
    logic [ADDR_W-1:0] p_addr;
    logic              wr_in;
    logic              ld_first;
    logic              ld_prev;
    logic              ld_op;
    logic              mom;
    logic              last;
    logic              mul_lo;
    logic              mul_hi;
    logic              scale;
    logic              wr_upd;
    logic [ADDR_W-1:0] wa;
    logic              emit_read;
    logic              emit_done;
  } ctrl_t;

endpackage

/* rtl/wave_equation_symplectic_step_top.sv */
// Top level of the 1-D periodic wave equation leapfrog step block.
// Depends on wes_pkg, wes_ctrl, wes_dp and the assertion macro header.
//
//  Channel   Handshake                       Payload
//  input     start / busy                    in_item  (cmd, index, position, momentum)
//  result    out_valid, one-cycle strobe     out_item (kind, index_res, position_res,
//                                                      momentum_res)
//  config    psel, penable, pwrite, pready   paddr, pwdata, prdata
//
// A read ends in a result strobe. A step makes four passes over the n grid
// points; each point of each pass goes through ST_RD, ST_LD, ST_M0, ST_M1,
// ST_SC and ST_WR around the single shared 17 x 31 multiplier, and each
// momentum pass first fetches its wraparound neighbours in ST_F0 to ST_F2.
// Reset is synchronous and active low; the stores keep their contents.
// busy is high from acceptance until the item's work is done.
module wave_equation_symplectic_step_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  wes_pkg::in_item_t   in_item,
  output logic                out_valid,
  output wes_pkg::out_item_t  out_item,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import wes_pkg::*;

  `include "wave_equation_symplectic_step_top_defines.svh"

  logic [HALF_W-1:0] half_step_r;
  logic [GAIN_W-1:0] gain_r;
  logic [NPTS_W-1:0] npts_r;
  logic              cfg_wr;
  ctrl_t             ctrl;

  // Configuration registers.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_step_r <= HALF_RESET;
      gain_r      <= GAIN_RESET;
      npts_r      <= NPTS_RESET;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_HALF_STEP: half_step_r <= pwdata[HALF_W-1:0];
        REG_GAIN:      gain_r      <= pwdata[GAIN_W-1:0];
        REG_NPTS:      npts_r      <= pwdata[NPTS_W-1:0];
        default:       npts_r      <= npts_r;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_HALF_STEP: prdata = 32'(half_step_r);
      REG_GAIN:      prdata = 32'(gain_r);
      REG_NPTS:      prdata = 32'(npts_r);
      default:       prdata = '0;
    endcase
  end

  wes_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .cmd   (in_item.cmd),
    .npts  (npts_r),
    .busy  (busy),
    .ctrl  (ctrl)
  );

  wes_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctrl         (ctrl),
    .in_item      (in_item),
    .half_step    (half_step_r),
    .stencil_gain (gain_r),
    .out_valid    (out_valid),
    .out_item     (out_item)
  );

  // A result is only strobed once the block has gone idle again.
  `WES_ASSERT_IMP(a_out_when_idle, clk, rst_n, out_valid, !busy)
  // Results never come in consecutive cycles.
  `WES_ASSERT_NXT(a_out_single, clk, rst_n, out_valid, !out_valid)
  // An accepted step keeps the block busy in the following cycle.
  `WES_ASSERT_NXT(a_step_busy, clk, rst_n, start && !busy && (in_item.cmd == CMD_STEP), busy)

endmodule

/* rtl/wes_ctrl.sv */
// Sequencing state machine of the wave equation step block.
// Depends on wes_pkg; drives the datapath through a ctrl_t command word.
module wes_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [1:0]                  cmd,
  input  logic [wes_pkg::NPTS_W-1:0]  npts,
  output logic                        busy,
  output wes_pkg::ctrl_t              ctrl
);
  import wes_pkg::*;

  state_t              state_r, state_nxt;
  logic [ADDR_W-1:0]   i_r, i_nxt;
  logic [1:0]          pass_r, pass_nxt;
  logic [NPTS_W-1:0]   n_r, n_nxt;
  logic [NPTS_W-1:0]   n_clamp;
  logic [NPTS_W-1:0]   n_m1;
  logic                last;

  // Grid size held to the legal range.
  always_comb begin
    if (npts < NPTS_MIN) begin
      n_clamp = NPTS_MIN;
    end else if (npts > NPTS_MAX) begin
      n_clamp = NPTS_MAX;
    end else begin
      n_clamp = npts;
    end
  end

  assign n_m1 = n_r - NPTS_W'(1);
  assign last = (i_r == n_m1[ADDR_W-1:0]);

  // State and counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      i_r     <= '0;
      pass_r  <= '0;
      n_r     <= NPTS_MIN;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      pass_r  <= pass_nxt;
      n_r     <= n_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    pass_nxt  = pass_r;
    n_nxt     = n_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          case (cmd)
            CMD_WRITE: state_nxt = ST_WRITE;
            CMD_READ:  state_nxt = ST_RD_ISSUE;
            CMD_STEP: begin
              state_nxt = ST_RD;
              i_nxt     = '0;
              pass_nxt  = '0;
              n_nxt     = n_clamp;
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_WRITE:    state_nxt = ST_IDLE;
      ST_RD_ISSUE: state_nxt = ST_RD_RESP;
      ST_RD_RESP:  state_nxt = ST_IDLE;
      ST_RD:       state_nxt = ST_LD;
      ST_LD:       state_nxt = ST_M0;
      ST_M0:       state_nxt = ST_M1;
      ST_M1:       state_nxt = ST_SC;
      ST_SC:       state_nxt = ST_WR;
      ST_WR: begin
        if (last) begin
          i_nxt = '0;
          if (pass_r == 2'd3) begin
            state_nxt = ST_DONE;
          end else begin
            pass_nxt  = pass_r + 2'd1;
            state_nxt = pass_r[0] ? ST_RD : ST_F0;
          end
        end else begin
          i_nxt     = i_r + ADDR_W'(1);
          state_nxt = ST_RD;
        end
      end
      ST_F0:   state_nxt = ST_F1;
      ST_F1:   state_nxt = ST_F2;
      ST_F2:   state_nxt = ST_RD;
      ST_DONE: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath commands.
  always_comb begin
    ctrl        = '0;
    ctrl.mom    = pass_r[0];
    ctrl.last   = last;
    ctrl.wa     = i_r;
    ctrl.p_addr = i_r;
    ctrl.q_addr = i_r;
    busy        = (state_r != ST_IDLE);
    case (state_r)
      ST_IDLE:     ctrl.cap_in = start;
      ST_WRITE:    ctrl.wr_in  = 1'b1;
      ST_RD_ISSUE: begin
        ctrl.rd_en   = 1'b1;
        ctrl.use_idx = 1'b1;
      end
      ST_RD_RESP:  ctrl.emit_read = 1'b1;
      ST_RD: begin
        ctrl.rd_en = 1'b1;
        if (pass_r[0]) begin
          ctrl.q_addr = i_r + ADDR_W'(1);
        end
      end
      ST_LD:   ctrl.ld_op  = 1'b1;
      ST_M0:   ctrl.mul_lo = 1'b1;
      ST_M1:   ctrl.mul_hi = 1'b1;
      ST_SC:   ctrl.scale  = 1'b1;
      ST_WR:   ctrl.wr_upd = 1'b1;
      ST_F0: begin
        ctrl.rd_en  = 1'b1;
        ctrl.q_addr = '0;
      end
      ST_F1: begin
        ctrl.ld_first = 1'b1;
        ctrl.rd_en    = 1'b1;
        ctrl.q_addr   = n_m1[ADDR_W-1:0];
      end
      ST_F2:   ctrl.ld_prev   = 1'b1;
      ST_DONE: ctrl.emit_done = 1'b1;
      default: ctrl = '0;
    endcase
  end

endmodule

/* rtl/wes_dp.sv */
// Datapath: grid stores, stencil registers, shared multiplier and result register.
// Depends on wes_pkg; commanded by wes_ctrl through ctrl_t.
module wes_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  wes_pkg::ctrl_t              ctrl,
  input  wes_pkg::in_item_t           in_item,
  input  logic [wes_pkg::HALF_W-1:0]  half_step,
  input  logic [wes_pkg::GAIN_W-1:0]  stencil_gain,
  output logic                        out_valid,
  output wes_pkg::out_item_t          out_item
);
  import wes_pkg::*;

  logic signed [DATA_W-1:0] q_mem [MAX_POINTS];
  logic signed [DATA_W-1:0] p_mem [MAX_POINTS];

  logic [ADDR_W-1:0]        idx_r;
  logic signed [DATA_W-1:0] pos_in_r, mom_in_r;
  logic signed [DATA_W-1:0] q_rd_r, p_rd_r;
  logic signed [DATA_W-1:0] first_r, prev_r, here_r, next_r;
  logic signed [DATA_W-1:0] acc_r, d_r;
  logic [MAG_W-1:0]         mag_r;
  logic                     neg_r;
  logic [PROD_W-1:0]        prod_lo_r, prod_hi_r;
  logic                     out_valid_r;
  out_item_t                out_r;

  logic [ADDR_W-1:0]        q_ra, p_ra;
  logic signed [DATA_W-1:0] next_val;
  logic signed [MAG_W-1:0]  op_val;
  logic [MAG_W-1:0]         op_mag;
  logic [GAIN_W-1:0]        gain;
  logic [PART_W-1:0]        mul_a;
  logic [PROD_W-1:0]        mul_y;
  logic [SUM_W-1:0]         sum;
  logic [SCL_W-1:0]         r;
  logic signed [DATA_W-1:0] d_val;
  logic signed [DATA_W:0]   upd_sum;
  logic signed [DATA_W-1:0] upd_val;
  logic                     q_we, p_we;
  logic [ADDR_W-1:0]        wa;
  logic signed [DATA_W-1:0] q_wd, p_wd;

  assign q_ra = ctrl.use_idx ? idx_r : ctrl.q_addr;
  assign p_ra = ctrl.use_idx ? idx_r : ctrl.p_addr;

  // Input capture at acceptance.
  always_ff @(posedge clk) begin
    if (ctrl.cap_in) begin
      idx_r    <= in_item.index;
      pos_in_r <= in_item.position;
      mom_in_r <= in_item.momentum;
    end
  end

  // Store write selection: a loaded point or an updated value.
  assign q_we = ctrl.wr_in || (ctrl.wr_upd && !ctrl.mom);
  assign p_we = ctrl.wr_in || (ctrl.wr_upd && ctrl.mom);
  assign wa   = ctrl.wr_in ? idx_r : ctrl.wa;
  assign q_wd = ctrl.wr_in ? pos_in_r : upd_val;
  assign p_wd = ctrl.wr_in ? mom_in_r : upd_val;

  // Position store, one write and one registered read port.
  always_ff @(posedge clk) begin
    if (q_we) begin
      q_mem[wa] <= q_wd;
    end
    if (ctrl.rd_en) begin
      q_rd_r <= q_mem[q_ra];
    end
  end

  // Momentum store, one write and one registered read port.
  always_ff @(posedge clk) begin
    if (p_we) begin
      p_mem[wa] <= p_wd;
    end
    if (ctrl.rd_en) begin
      p_rd_r <= p_mem[p_ra];
    end
  end

  // Operand: momentum for a position pass, Laplacian for a momentum pass.
  assign next_val = ctrl.last ? first_r : q_rd_r;
  always_comb begin
    if (ctrl.mom) begin
      op_val = MAG_W'(prev_r) - (MAG_W'(here_r) <<< 1) + MAG_W'(next_val);
    end else begin
      op_val = MAG_W'(p_rd_r);
    end
    op_mag = op_val[MAG_W-1] ? MAG_W'(-op_val) : MAG_W'(op_val);
  end

  // Stencil line registers and operand registers.
  always_ff @(posedge clk) begin
    if (ctrl.ld_first) begin
      first_r <= q_rd_r;
      here_r  <= q_rd_r;
    end
    if (ctrl.ld_prev) begin
      prev_r <= q_rd_r;
    end
    if (ctrl.ld_op) begin
      mag_r  <= op_mag;
      neg_r  <= op_val[MAG_W-1];
      acc_r  <= ctrl.mom ? p_rd_r : q_rd_r;
      next_r <= next_val;
    end
    if (ctrl.wr_upd && ctrl.mom) begin
      prev_r <= here_r;
      here_r <= next_r;
    end
  end

  // Shared multiplier: low half of the magnitude, then the high half.
  assign gain  = ctrl.mom ? stencil_gain : GAIN_W'(half_step);
  assign mul_a = ctrl.mul_hi ? mag_r[MAG_W-1:PART_W] : mag_r[PART_W-1:0];
  assign mul_y = PROD_W'(mul_a) * PROD_W'(gain);

  always_ff @(posedge clk) begin
    if (ctrl.mul_lo) begin
      prod_lo_r <= mul_y;
    end
    if (ctrl.mul_hi) begin
      prod_hi_r <= mul_y;
    end
  end

  // Rounded, saturated rescale of the product.
  always_comb begin
    sum = (SUM_W'(prod_hi_r) << PART_W) + SUM_W'(prod_lo_r)
        + (SUM_W'(1) << (FRAC_BITS - 1));
    r   = sum[SUM_W-1:FRAC_BITS];
    if (neg_r) begin
      if (r > (SCL_W'(1) << (DATA_W - 1))) begin
        d_val = {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
        d_val = -$signed(r[DATA_W-1:0]);
      end
    end else begin
      if (r > SCL_W'({1'b0, {(DATA_W-1){1'b1}}})) begin
        d_val = {1'b0, {(DATA_W-1){1'b1}}};
      end else begin
        d_val = $signed(r[DATA_W-1:0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.scale) begin
      d_r <= d_val;
    end
  end

  // Saturating accumulate into the stored value.
  always_comb begin
    upd_sum = (DATA_W+1)'(acc_r) + (DATA_W+1)'(d_r);
    if (upd_sum[DATA_W] != upd_sum[DATA_W-1]) begin
      upd_val = upd_sum[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end else begin
      upd_val = upd_sum[DATA_W-1:0];
    end
  end

  // Result register: one strobe cycle per result item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ctrl.emit_read || ctrl.emit_done;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit_read) begin
      out_r.kind         <= KIND_READ;
      out_r.index_res    <= idx_r;
      out_r.position_res <= q_rd_r;
      out_r.momentum_res <= p_rd_r;
    end else if (ctrl.emit_done) begin
      out_r.kind         <= KIND_DONE;
      out_r.index_res    <= '0;
      out_r.position_res <= '0;
      out_r.momentum_res <= '0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule
